// ----- rtl/mp2_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_pkg
// Shared types and constants of the 2x2 max pooling block with argmax.
// ----------------------------------------------------------------------------
package mp2_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_OUTPUTS = 65536;
  localparam int MAX_HEIGHT      = 1024;

  localparam int SW  = 16;  // sample width, Q8.8
  localparam int CDW = 11;  // config data width
  localparam int HW  = 11;  // height register width
  localparam int RW  = 10;  // row counter width
  localparam int PSW = 2;   // window position width {row, col}

  typedef logic signed [SW-1:0] sample_t;
  typedef logic [PSW-1:0]       wpos_t;

  localparam sample_t FLOOR_Q88 = 16'sd25600 * -16'sd1;

  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_BWD = 1'b1;

  localparam logic REG_IN_WIDTH  = 1'b0;
  localparam logic REG_IN_HEIGHT = 1'b1;

endpackage

// ----- rtl/mp2_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_if
// Valid/ready channels of the pooling block: input, result and config write.
// ----------------------------------------------------------------------------
interface mp2_in_if;
  import mp2_pkg::*;
  logic    valid;
  logic    ready;
  logic    cmd;
  sample_t sample_value;
  logic    first;

  modport source (output valid, cmd, sample_value, first, input ready);
  modport sink   (input valid, cmd, sample_value, first, output ready);
endinterface

interface mp2_out_if;
  import mp2_pkg::*;
  logic    valid;
  logic    ready;
  sample_t result_value;
  logic    win_row;
  logic    win_col;
  logic    last;

  modport source (output valid, result_value, win_row, win_col, last, input ready);
  modport sink   (input valid, result_value, win_row, win_col, last, output ready);
endinterface

interface mp2_cfg_if;
  import mp2_pkg::*;
  logic           valid;
  logic           ready;
  logic           index;
  logic [CDW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mp2_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_ram
// Single-clock RAM, one write and one registered read port, write-first on a
// read of the address being written in the same cycle.
// ----------------------------------------------------------------------------
module mp2_ram #(
  parameter int DEPTH = 512,
  parameter int DW    = 18,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mp2_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_cfg
// Geometry registers, clamped to the supported range when written.
// ----------------------------------------------------------------------------
module mp2_cfg import mp2_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  mp2_cfg_if.sink       cfg_ch,
  output logic [WW-1:0] width,
  output logic [HW-1:0] height
);

  logic [WW-1:0] width_r, width_nxt;
  logic [HW-1:0] height_r, height_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IN_WIDTH: begin
          if (cfg_ch.data < CDW'(2)) begin
            width_nxt = WW'(2);
          end else if (32'(cfg_ch.data) > MAX_WIDTH) begin
            width_nxt = WW'(MAX_WIDTH);
          end else begin
            width_nxt = WW'(cfg_ch.data);
          end
        end
        REG_IN_HEIGHT: begin
          if (cfg_ch.data < CDW'(2)) begin
            height_nxt = HW'(2);
          end else if (32'(cfg_ch.data) > MAX_HEIGHT) begin
            height_nxt = HW'(MAX_HEIGHT);
          end else begin
            height_nxt = HW'(cfg_ch.data);
          end
        end
        default: begin
          width_nxt  = width_r;
          height_nxt = height_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(2);
      height_r <= HW'(2);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign width  = width_r;
  assign height = height_r;

endmodule

// ----- rtl/maxpool_2x2_with_argmax_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maxpool_2x2_with_argmax_core
// 2x2 stride-2 max pooling with argmax capture and gradient routing.
//
// in_ch takes one item per cycle unless a gradient or an out_ch stall holds
// it: cmd 0 is a forward sample in raster order, cmd 1 a gradient of one
// pooled output; first restarts counts and pointers. A forward item that
// closes a window gives one result (max and position in the window) via the
// stage and output registers; other forward items give none. A gradient
// gives four results, one per window position, and holds the block until the
// fourth; results and forward samples go one per cycle while out_ch is ready.
// Window partial maxima live in a line RAM and positions in a position RAM,
// both read on acceptance and written when the stage register fires, with
// write-first bypass for back-to-back access to the same entry.
// cfg_ch writes in_width (index 0) and in_height (index 1) only while idle,
// a user rule the block does not enforce. Reset clears counters and pointers
// and sets a 2x2 geometry; RAM contents are not cleared. When out_ch stalls
// the output register and the stage behind it hold, and in_ch.ready drops.
// ----------------------------------------------------------------------------
module maxpool_2x2_with_argmax_core import mp2_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic       clk,
  input  logic       rst_n,
  mp2_in_if.sink     in_ch,
  mp2_out_if.source  out_ch,
  mp2_cfg_if.sink    cfg_ch
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int PW         = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int LDW        = SW + PSW;

  localparam logic [1:0] OP_PAIR  = 2'd0;
  localparam logic [1:0] OP_MERGE = 2'd1;
  localparam logic [1:0] OP_EMIT  = 2'd2;
  localparam logic [1:0] OP_BACK  = 2'd3;

  logic [WW-1:0] width;
  logic [HW-1:0] height;

  mp2_cfg #(.MAX_WIDTH(MAX_WIDTH), .WW(WW)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .width  (width),
    .height (height)
  );

  // state
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  sample_t       pair_max_r, pair_max_nxt;
  logic          pair_col_r, pair_col_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;

  logic          s1_valid_r;
  logic [1:0]    s1_op_r;
  sample_t       s1_val_r;
  logic          s1_aux_r;
  logic [LW-1:0] s1_li_r;
  logic [PW-1:0] s1_wp_r;
  logic [1:0]    beat_r;

  logic          out_valid_r;
  sample_t       out_val_r;
  logic          out_row_r;
  logic          out_col_r;
  logic          out_last_r;

  // front stage
  logic          accept, is_fwd;
  logic [CW-1:0] c0;
  logic [RW-1:0] r0;
  logic [CW:0]   c1;
  logic [RW:0]   r1;
  logic          in_win, emit0, s1_load;
  logic [LW-1:0] li0;
  logic [PW-1:0] wp0, rp0;
  logic [1:0]    op0;
  sample_t       v0, val0;
  logic          aux0;

  // back stage
  logic [LDW-1:0] line_rdata, line_wdata;
  wpos_t          pos_rdata;
  logic           line_we, line_re, pos_we, pos_re;
  sample_t        m_rd, m_new;
  wpos_t          p_rd, p_new;
  logic           needs_out, out_free, s1_fire, s1_done;
  sample_t        res_val;
  logic           res_row, res_col, res_last;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(MAX_OUTPUTS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign accept = in_ch.valid && in_ch.ready;
  assign is_fwd = (in_ch.cmd == CMD_FWD);
  assign v0     = in_ch.sample_value;

  always_comb begin
    c0      = in_ch.first ? '0 : col_r;
    r0      = in_ch.first ? '0 : row_r;
    c1      = {1'b0, c0} + 1'b1;
    r1      = {1'b0, r0} + 1'b1;
    in_win  = (32'(c0) < 32'({width[WW-1:1], 1'b0})) &&
              (32'(r0) < 32'({height[HW-1:1], 1'b0}));
    li0     = LW'(c0 >> 1);
    emit0   = in_win && r0[0] && c0[0];
    wp0     = in_ch.first ? '0 : wp_r;
    rp0     = in_ch.first ? '0 : rp_r;

    col_nxt      = col_r;
    row_nxt      = row_r;
    pair_max_nxt = pair_max_r;
    pair_col_nxt = pair_col_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    op0          = OP_BACK;
    val0         = v0;
    aux0         = c0[0];
    s1_load      = 1'b0;

    if (accept) begin
      if (!is_fwd) begin
        rp_nxt  = ptr_inc(rp0);
        op0     = OP_BACK;
        s1_load = 1'b1;
      end else begin
        wp_nxt = emit0 ? ptr_inc(wp0) : wp0;
        rp_nxt = rp0;
        if (32'(c1) >= 32'(width)) begin
          col_nxt = '0;
          row_nxt = (32'(r1) >= 32'(height)) ? '0 : r1[RW-1:0];
        end else begin
          col_nxt = c1[CW-1:0];
          row_nxt = r0;
        end
        if (in_win) begin
          if (!r0[0]) begin
            if (!c0[0]) begin
              pair_max_nxt = (v0 > FLOOR_Q88) ? v0 : FLOOR_Q88;
              pair_col_nxt = 1'b0;
            end else begin
              if (v0 > pair_max_r) begin
                pair_max_nxt = v0;
                pair_col_nxt = 1'b1;
              end
              op0     = OP_PAIR;
              val0    = pair_max_nxt;
              aux0    = pair_col_nxt;
              s1_load = 1'b1;
            end
          end else begin
            op0     = c0[0] ? OP_EMIT : OP_MERGE;
            s1_load = 1'b1;
          end
        end
      end
    end
  end

  // line store of per-window running maxima
  assign line_re    = accept && is_fwd && in_win && r0[0];
  assign line_we    = s1_fire && ((s1_op_r == OP_PAIR) || (s1_op_r == OP_MERGE));
  assign line_wdata = (s1_op_r == OP_PAIR) ? {s1_val_r, 1'b0, s1_aux_r} : {m_new, p_new};

  mp2_ram #(.DEPTH(LINE_DEPTH), .DW(LDW), .AW(LW)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_li_r),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (li0),
    .rdata (line_rdata)
  );

  // argmax position store
  assign pos_re = accept && !is_fwd;
  assign pos_we = s1_fire && (s1_op_r == OP_EMIT);

  mp2_ram #(.DEPTH(MAX_OUTPUTS), .DW(PSW), .AW(PW)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (s1_wp_r),
    .wdata (p_new),
    .re    (pos_re),
    .raddr (rp0),
    .rdata (pos_rdata)
  );

  always_comb begin
    m_rd      = $signed(line_rdata[LDW-1:PSW]);
    p_rd      = line_rdata[PSW-1:0];
    m_new     = (s1_val_r > m_rd) ? s1_val_r : m_rd;
    p_new     = (s1_val_r > m_rd) ? {1'b1, s1_aux_r} : p_rd;
    needs_out = (s1_op_r == OP_EMIT) || (s1_op_r == OP_BACK);
    out_free  = !out_valid_r || out_ch.ready;
    s1_fire   = s1_valid_r && (!needs_out || out_free);
    s1_done   = s1_fire && ((s1_op_r != OP_BACK) || (beat_r == 2'd3));

    case (s1_op_r)
      OP_EMIT: begin
        res_val  = m_new;
        res_row  = p_new[1];
        res_col  = p_new[0];
        res_last = 1'b1;
      end
      OP_BACK: begin
        res_val  = (beat_r == pos_rdata) ? s1_val_r : '0;
        res_row  = beat_r[1];
        res_col  = beat_r[0];
        res_last = (beat_r == 2'd3);
      end
      default: begin
        res_val  = '0;
        res_row  = 1'b0;
        res_col  = 1'b0;
        res_last = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = !s1_valid_r || s1_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      pair_max_r  <= '0;
      pair_col_r  <= 1'b0;
      wp_r        <= '0;
      rp_r        <= '0;
      s1_valid_r  <= 1'b0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pair_max_r <= pair_max_nxt;
      pair_col_r <= pair_col_nxt;
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire && (s1_op_r == OP_BACK)) begin
        beat_r <= beat_r + 1'b1;
      end
      if (s1_fire && needs_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r  <= op0;
      s1_val_r <= val0;
      s1_aux_r <= aux0;
      s1_li_r  <= li0;
      s1_wp_r  <= wp0;
    end
    if (s1_fire && needs_out) begin
      out_val_r  <= res_val;
      out_row_r  <= res_row;
      out_col_r  <= res_col;
      out_last_r <= res_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.win_row      = out_row_r;
  assign out_ch.win_col      = out_col_r;
  assign out_ch.last         = out_last_r;

endmodule

// ----- tb/sv/mp2_argmax_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_argmax_checker
// Watches the config, input and result channels of the 2x2 max pooling core.
// Keeps its own copy of the window state, line store and argmax store, works
// out the results of every accepted item and compares each accepted result
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module mp2_argmax_checker import mp2_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mp2_in_if    in_ch,
  mp2_out_if   out_ch,
  mp2_cfg_if   cfg_ch,
  output int   fail_count,
  output int   outstanding,
  output int   results_checked
);

  localparam int LINE_DEPTH = DEF_MAX_WIDTH / 2;
  localparam int PTR_W      = $clog2(DEF_MAX_OUTPUTS);

  typedef struct {
    sample_t value;
    logic    row;
    logic    col;
    logic    last;
  } pool_result_t;

  pool_result_t     pool_results_q[$];
  logic [CDW-1:0]   width_reg;
  logic [CDW-1:0]   height_reg;
  int               col_pos;
  int               row_pos;
  sample_t          top_max;
  logic             top_col;
  sample_t          line_max [LINE_DEPTH];
  wpos_t            line_pos [LINE_DEPTH];
  wpos_t            argmax_store [DEF_MAX_OUTPUTS];
  logic [PTR_W-1:0] store_wr;
  logic [PTR_W-1:0] store_rd;

  function automatic int clamp_dim(int v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_result(sample_t v, logic r, logic c, logic l);
    pool_result_t e;
    e.value = v;
    e.row   = r;
    e.col   = c;
    e.last  = l;
    pool_results_q.insert(pool_results_q.size(), e);
  endtask

  task automatic pool_predict(logic cmd, sample_t v, logic first);
    int      w;
    int      h;
    int      li;
    sample_t m;
    wpos_t   p;
    if (cmd == CMD_BWD) begin
      if (first) store_rd = '0;
      p = argmax_store[store_rd];
      for (int k = 0; k < 4; k++) begin
        push_result((k == int'(p)) ? v : sample_t'(0), k[1], k[0], k == 3);
      end
      store_rd++;
      return;
    end
    w = clamp_dim(int'(width_reg), DEF_MAX_WIDTH);
    h = clamp_dim(int'(height_reg), MAX_HEIGHT);
    if (first) begin
      col_pos  = 0;
      row_pos  = 0;
      store_wr = '0;
      store_rd = '0;
    end
    li = (col_pos >> 1) % LINE_DEPTH;
    // trailing odd column or row is consumed without effect
    if (col_pos < 2 * (w / 2) && row_pos < 2 * (h / 2)) begin
      if (row_pos[0] == 1'b0) begin
        if (col_pos[0] == 1'b0) begin
          top_max = (v > FLOOR_Q88) ? v : FLOOR_Q88;
          top_col = 1'b0;
        end else begin
          if (v > top_max) begin
            top_max = v;
            top_col = 1'b1;
          end
          line_max[li] = top_max;
          line_pos[li] = {1'b0, top_col};
        end
      end else begin
        m = line_max[li];
        p = line_pos[li];
        if (v > m) begin
          m = v;
          p = {1'b1, col_pos[0]};
        end
        if (col_pos[0] == 1'b0) begin
          line_max[li] = m;
          line_pos[li] = p;
        end else begin
          argmax_store[store_wr] = p;
          store_wr++;
          push_result(m, p[1], p[0], 1'b1);
        end
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    pool_result_t want;
    if (!rst_n) begin
      pool_results_q.delete();
      width_reg  = CDW'(2);
      height_reg = CDW'(2);
      col_pos    = 0;
      row_pos    = 0;
      top_max    = '0;
      top_col    = 1'b0;
      store_wr   = '0;
      store_rd   = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_IN_WIDTH) width_reg = cfg_ch.data;
        else height_reg = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        pool_predict(in_ch.cmd, in_ch.sample_value, in_ch.first);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (pool_results_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", results_checked));
        end else begin
          want = pool_results_q.pop_front();
          if (out_ch.result_value !== want.value)
            report($sformatf("result %0d value got %0d want %0d", results_checked,
                             out_ch.result_value, want.value));
          if (out_ch.win_row !== want.row)
            report($sformatf("result %0d win_row got %b want %b", results_checked,
                             out_ch.win_row, want.row));
          if (out_ch.win_col !== want.col)
            report($sformatf("result %0d win_col got %b want %b", results_checked,
                             out_ch.win_col, want.col));
          if (out_ch.last !== want.last)
            report($sformatf("result %0d last got %b want %b", results_checked,
                             out_ch.last, want.last));
        end
      end
    end
    outstanding = pool_results_q.size();
  end

endmodule

// ----- tb/sv/tb_maxpool_2x2_with_argmax_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_maxpool_2x2_with_argmax_core
// Drives forward planes, gradient runs, stray items and geometry writes into
// the pooling core under three stall mixes, with a checker alongside that
// predicts and compares every result. Reports the verdict at the end.
// ----------------------------------------------------------------------------
module tb_maxpool_2x2_with_argmax_core;
  import mp2_pkg::*;

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   n_samples;
  int   n_grads;
  int   n_writes;
  int   geo_w;
  int   geo_h;
  int   trk_col;
  int   trk_row;
  int   trk_wr;
  int   trk_rd;
  int   trk_written;
  int   fail_count;
  int   outstanding;
  int   results_checked;

  mp2_in_if  in_ch ();
  mp2_out_if out_ch ();
  mp2_cfg_if cfg_ch ();

  maxpool_2x2_with_argmax_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mp2_argmax_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic int clamp_dim(int v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic sample_t rand_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return sample_t'($urandom);
    if (sel < 55) return sample_t'(int'(FLOOR_Q88) + int'($urandom_range(4)) - 2);
    if (sel < 70) begin
      case ($urandom_range(3))
        0: return sample_t'(32767);
        1: return sample_t'(-32768);
        2: return sample_t'(0);
        default: return sample_t'(-1);
      endcase
    end
    if (sel < 90) return sample_t'(int'($urandom_range(3)) - 1);
    return sample_t'(int'($urandom_range(200)) - 100);
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(9))
      0: return $urandom_range(1);
      1: return 3;
      default: return $urandom_range(7, 2);
    endcase
  endfunction

  task automatic drive_item(logic c, sample_t v, logic f);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= c;
    in_ch.sample_value <= v;
    in_ch.first        <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // tracks which argmax entries hold data so no gradient reads an unwritten one
  task automatic send_sample(sample_t v, logic f);
    if (f) begin
      trk_col = 0;
      trk_row = 0;
      trk_wr  = 0;
      trk_rd  = 0;
    end
    if (trk_row % 2 == 1 && trk_col % 2 == 1 &&
        trk_col < 2 * (geo_w / 2) && trk_row < 2 * (geo_h / 2)) begin
      trk_wr++;
      if (trk_wr > trk_written) trk_written = trk_wr;
    end
    trk_col++;
    if (trk_col >= geo_w) begin
      trk_col = 0;
      trk_row++;
      if (trk_row >= geo_h) trk_row = 0;
    end
    n_samples++;
    drive_item(CMD_FWD, v, f);
  endtask

  task automatic send_grad(sample_t v, logic f);
    if (f) trk_rd = 0;
    trk_rd++;
    n_grads++;
    drive_item(CMD_BWD, v, f);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CDW'(val);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    n_writes++;
    @(posedge clk);
  endtask

  task automatic set_geometry(int w, int h);
    drain();
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_IN_HEIGHT, h);
    geo_w = clamp_dim(w, DEF_MAX_WIDTH);
    geo_h = clamp_dim(h, MAX_HEIGHT);
  endtask

  task automatic run_tensor(int w, int h);
    int n_win;
    set_geometry(w, h);
    for (int i = 0; i < geo_w * geo_h; i++) send_sample(rand_sample(), i == 0);
    n_win = (geo_w / 2) * (geo_h / 2);
    if ($urandom_range(2) == 0) drain();
    if ($urandom_range(3) == 0) n_win = $urandom_range(n_win, 1);
    for (int i = 0; i < n_win; i++) send_grad(rand_sample(), i == 0);
  endtask

  initial begin
    int   windows_a [12];
    int   odd_plane [9];
    logic f;
    windows_a = '{-32768, -30000, -25601, -25600, 5, 5, 9, 9, -1, 200, 100, 200};
    odd_plane = '{1, 2, 50, 3, 9, 60, 70, 80, 90};
    src_idle_pct = 10;
    snk_idle_pct = 64;
    geo_w        = 2;
    geo_h        = 2;
    trk_col      = 0;
    trk_row      = 0;
    trk_wr       = 0;
    trk_rd       = 0;
    trk_written  = 0;
    n_samples    = 0;
    n_grads      = 0;
    n_writes     = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_FWD;
    in_ch.sample_value <= '0;
    in_ch.first        <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_IN_WIDTH;
    cfg_ch.data        <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // below floor, ties and argmax positions 0, 1 and 2 on the reset geometry
    foreach (windows_a[i]) send_sample(sample_t'(windows_a[i]), i == 0);
    send_grad(sample_t'(32767), 1'b1);
    send_grad(sample_t'(-1), 1'b0);
    send_grad(sample_t'(-32768), 1'b1);
    // odd column and odd row are dropped
    set_geometry(3, 3);
    foreach (odd_plane[i]) send_sample(sample_t'(odd_plane[i]), i == 0);
    // geometry shrinks mid plane
    set_geometry(6, 2);
    send_sample(sample_t'(10), 1'b1);
    send_sample(sample_t'(20), 1'b0);
    send_sample(sample_t'(30), 1'b0);
    set_geometry(2, 2);
    send_sample(sample_t'(40), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(-7), 1'b0);

    while (n_samples + n_grads < 140) begin
      if (n_samples + n_grads >= 100) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (n_samples + n_grads >= 55) begin
        src_idle_pct = 64;
        snk_idle_pct = 10;
      end
      if ($urandom_range(99) < 70) begin
        run_tensor(pick_dim(), pick_dim());
      end else begin
        repeat ($urandom_range(6, 1)) begin
          f = ($urandom_range(9) == 0);
          if ($urandom_range(1) == 1 && (f ? trk_written > 0 : trk_rd < trk_written))
            send_grad(rand_sample(), f);
          else
            send_sample(rand_sample(), f);
        end
      end
    end
    // geometry registers written above their range
    set_geometry(2047, 2);
    for (int i = 0; i < 8; i++) send_sample(rand_sample(), i == 0);
    set_geometry(3, 2047);
    for (int i = 0; i < 10; i++) send_sample(rand_sample(), 1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("run: %0d samples and %0d gradients, %0d register writes, three stall mixes",
             n_samples, n_grads, n_writes);
    $display("run: %0d results checked, %0d mismatches, %0d still waiting",
             results_checked, fail_count, outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mp2_pkg.sv
rtl/mp2_if.sv
rtl/mp2_ram.sv
rtl/mp2_cfg.sv
rtl/maxpool_2x2_with_argmax_core.sv
tb/sv/mp2_argmax_checker.sv
tb/sv/tb_maxpool_2x2_with_argmax_core.sv
